@@ design/tpsd_pkg.sv @@
package tpsd_pkg;

  localparam int POS_BITS = 32;
  localparam int TFB      = 16;                   // fraction bits of times and rates
  localparam int RATE_W   = 32;
  localparam int TQ_W     = 16;
  localparam int LIM_W    = 15;
  localparam int WIN_W    = 16;
  localparam int DIST_W   = POS_BITS + 1;
  localparam int DIV_W    = DIST_W + 3 * TFB;     // widest dividend: dist << 3F
  localparam int ROOT_W   = RATE_W;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam int PROD_W   = 3 * RATE_W;           // a * x * y
  localparam int OFF_W    = PROD_W - 3 * TFB + 1; // sum of two shifted terms
  localparam int SP_W     = OFF_W + 2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CFG_ACCEL_MAG  = 3'd0,
    CFG_CRUISE_VEL = 3'd1,
    CFG_TLIM_A     = 3'd2,
    CFG_TLIM_B     = 3'd3,
    CFG_TLIM_C     = 3'd4,
    CFG_WINDOW_LEN = 3'd5,
    CFG_TRIP_COUNT = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VV,
    S_THR_GO,
    S_THR_W,
    S_TRI_GO,
    S_TRI_W,
    S_SQ_GO,
    S_SQ_W,
    S_RMP_GO,
    S_RMP_W,
    S_CST_GO,
    S_CST_W,
    S_PLAN_END,
    S_MP,
    S_MLO,
    S_MHI,
    S_ACC,
    S_TICK_END,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                       func;
    logic [1:0]                 joint;
    logic signed [POS_BITS-1:0] start_pos;
    logic signed [POS_BITS-1:0] end_pos;
    logic signed [TQ_W-1:0]     measured_torque;
    logic signed [POS_BITS-1:0] actual_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] setpoint;
    logic                       moving;
    logic                       engaged;
    logic [1:0]                 phase;
  } out_item_t;

endpackage

@@ design/tpsd_divsqrt.sv @@
module tpsd_divsqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpsd_pkg::ds_req_t            req,
  input  logic [tpsd_pkg::DIV_W-1:0]   dividend,
  input  logic [tpsd_pkg::RATE_W-1:0]  divisor,
  output logic                         done,
  output logic [tpsd_pkg::DIV_W-1:0]   quot
);
  import tpsd_pkg::*;

  // one subtractor shared by restoring division and digit-by-digit root
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  ds_op_t            op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  shreg_r, shreg_nxt;
  logic [RATE_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RATE_W-1:0] d_r, d_nxt;

  logic [RATE_W+1:0] sub_a, sub_b, rem_step;
  logic [RATE_W+2:0] diff;
  logic              ge;

  always_comb begin
    if (op_r == DS_DIV) begin
      sub_a = {rem_r[RATE_W:0], shreg_r[DIV_W-1]};
      sub_b = {2'b00, d_r};
    end else begin
      sub_a = {rem_r[RATE_W-1:0], shreg_r[DIV_W-1 -: 2]};
      sub_b = {root_r, 2'b01};
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    ge       = ~diff[RATE_W+2];
    rem_step = ge ? diff[RATE_W+1:0] : sub_a;
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    d_nxt     = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      d_nxt    = divisor;
      rem_nxt  = '0;
      root_nxt = '0;
      if (req.op == DS_DIV) begin
        cnt_nxt   = CNT_W'(DIV_W);
        shreg_nxt = dividend;
      end else begin
        cnt_nxt   = CNT_W'(ROOT_W);
        shreg_nxt = {dividend[SQ_W-1:0], {(DIV_W-SQ_W){1'b0}}};
      end
    end else if (busy_r) begin
      rem_nxt = rem_step;
      if (op_r == DS_DIV) begin
        shreg_nxt = {shreg_r[DIV_W-2:0], ge};
      end else begin
        shreg_nxt = {shreg_r[DIV_W-3:0], 2'b00};
        root_nxt  = {root_r[ROOT_W-2:0], ge};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= DS_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    d_r     <= d_nxt;
  end

  assign done = done_r;
  assign quot = (op_r == DS_DIV) ? shreg_r : {{(DIV_W-ROOT_W){1'b0}}, root_r};

endmodule

@@ design/trapezoid_profile_stall_detect.sv @@
// Start item: three 81-step divisions for a trapezoidal plan,
// two divisions and a 32-step root for a triangular one, none for no move.
// Tick item: one 32x32 multiplier, 3 passes, or 6 while cruising; an idle tick
// uses no multiplier. One item at a time; in_stall is high while an item is worked.
// The result register lets the next item start while a result waits on out_stall.
// rst_n is synchronous, active low; it restores register defaults, control and move state.
module trapezoid_profile_stall_detect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import tpsd_pkg::*;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // configuration registers
  logic [RATE_W-1:0] accel_r, cruise_r;
  logic [LIM_W-1:0]  tlim_a_r, tlim_b_r, tlim_c_r;
  logic [WIN_W-1:0]  win_len_r, trip_cnt_r;

  // move state
  logic signed [POS_BITS-1:0] origin_r, origin_nxt, target_r, target_nxt;
  logic signed [POS_BITS-1:0] held_r, held_nxt;
  logic                       dir_neg_r, dir_neg_nxt;
  logic [RATE_W-1:0]          ramp_r, ramp_nxt, coast_r, coast_nxt;
  logic [RATE_W-1:0]          elapsed_r, elapsed_nxt;
  logic [WIN_W-1:0]           win_ticks_r, win_ticks_nxt, over_r, over_nxt;
  logic [1:0]                 lim_sel_r, lim_sel_nxt;
  logic                       active_r, active_nxt, tripped_r, tripped_nxt;

  // sequencer and work registers
  state_t                     st_r, st_nxt;
  logic [DIST_W-1:0]          dist_r, dist_nxt;
  logic [SQ_W-1:0]            preg_r, preg_nxt;
  logic [PROD_W-1:0]          acc_r, acc_nxt;
  logic [OFF_W-1:0]           off_r, off_nxt;
  phase_t                     ph_r, ph_nxt;
  logic                       term_r, term_nxt;
  logic signed [TQ_W-1:0]     tq_r, tq_nxt;
  logic signed [POS_BITS-1:0] act_r, act_nxt;
  out_item_t                  res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;

  // shared unit ports
  ds_req_t           ds_req;
  logic [DIV_W-1:0]  ds_dividend, ds_quot;
  logic [RATE_W-1:0] ds_divisor;
  logic              ds_done;

  tpsd_divsqrt u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ds_req),
    .dividend (ds_dividend),
    .divisor  (ds_divisor),
    .done     (ds_done),
    .quot     (ds_quot)
  );

  // zero rates behave as one
  logic [RATE_W-1:0] a_eff, v_eff;
  assign a_eff = (accel_r == '0) ? RATE_W'(1) : accel_r;
  assign v_eff = (cruise_r == '0) ? RATE_W'(1) : cruise_r;

  // total move time, saturated
  logic [RATE_W+1:0] tot_sum;
  logic [RATE_W-1:0] total;
  assign tot_sum = {1'b0, ramp_r, 1'b0} + {2'b00, coast_r};
  assign total   = (tot_sum[RATE_W+1:RATE_W] != 2'b00) ? RATE_MAX : tot_sum[RATE_W-1:0];

  // quotient clipped to 32 bits
  logic [RATE_W-1:0] q_sat;
  assign q_sat = (ds_quot[DIV_W-1:RATE_W] != '0) ? RATE_MAX : ds_quot[RATE_W-1:0];

  // the one multiplier, 32x32
  logic [RATE_W-1:0] mul_a, mul_b, op_x, op_y;
  logic [SQ_W-1:0]   prod;
  assign prod = mul_a * mul_b;

  always_comb begin
    case (ph_r)
      PH_ACCEL: begin
        op_x = elapsed_r;
        op_y = elapsed_r;
      end
      PH_CRUISE: begin
        op_x = ramp_r;
        op_y = term_r ? (elapsed_r - ramp_r) : ramp_r;
      end
      default: begin
        op_x = total - elapsed_r;
        op_y = total - elapsed_r;
      end
    endcase
  end

  always_comb begin
    case (st_r)
      S_VV: begin
        mul_a = v_eff;
        mul_b = v_eff;
      end
      S_MP: begin
        mul_a = op_x;
        mul_b = op_y;
      end
      S_MLO: begin
        mul_a = preg_r[RATE_W-1:0];
        mul_b = a_eff;
      end
      S_MHI: begin
        mul_a = preg_r[SQ_W-1:RATE_W];
        mul_b = a_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // start-item decode
  logic [DIST_W-1:0] diff_s;
  logic              neg_s;
  logic [DIST_W-1:0] dist_s;
  assign diff_s = {in_data.end_pos[POS_BITS-1], in_data.end_pos}
                - {in_data.start_pos[POS_BITS-1], in_data.start_pos};
  assign neg_s  = diff_s[DIST_W-1];
  assign dist_s = neg_s ? (~diff_s + 1'b1) : diff_s;

  // tick phase decision
  phase_t tick_ph;
  always_comb begin
    if (elapsed_r < ramp_r) begin
      tick_ph = PH_ACCEL;
    end else if ({1'b0, elapsed_r} < ({1'b0, ramp_r} + {1'b0, coast_r})) begin
      tick_ph = PH_CRUISE;
    end else begin
      tick_ph = PH_DECEL;
    end
  end

  // offset term: product >> 3F, or >> 3F+1 for the squared terms
  logic [PROD_W-1:0] acc_sh;
  logic              half;
  assign half   = !(ph_r == PH_CRUISE && term_r);
  assign acc_sh = half ? (acc_r >> (3 * TFB + 1)) : (acc_r >> (3 * TFB));

  // setpoint, saturated to the position range
  localparam logic signed [SP_W-1:0] SP_MAX = SP_W'((64'sd1 <<< (POS_BITS - 1)) - 1);
  localparam logic signed [SP_W-1:0] SP_MIN = ~SP_MAX;
  logic                       early, sub_off;
  logic signed [POS_BITS-1:0] base;
  logic signed [SP_W-1:0]     base_x, off_x, sum_x;
  logic signed [POS_BITS-1:0] sp;
  assign early   = ph_r inside {PH_ACCEL, PH_CRUISE};
  assign sub_off = early ? dir_neg_r : !dir_neg_r;
  assign base    = early ? origin_r : target_r;
  assign base_x  = {{(SP_W-POS_BITS){base[POS_BITS-1]}}, base};
  assign off_x   = {2'b00, off_r};
  assign sum_x   = sub_off ? (base_x - off_x) : (base_x + off_x);
  assign sp      = (sum_x > SP_MAX) ? SP_MAX[POS_BITS-1:0] :
                   (sum_x < SP_MIN) ? SP_MIN[POS_BITS-1:0] : sum_x[POS_BITS-1:0];

  // elapsed advance, saturated
  logic [RATE_W:0]   el_sum;
  logic [RATE_W-1:0] el_new;
  assign el_sum = {1'b0, elapsed_r} + ((RATE_W + 1)'(1) << TFB);
  assign el_new = el_sum[RATE_W] ? RATE_MAX : el_sum[RATE_W-1:0];

  // torque sample
  logic [TQ_W:0]    tq_mag;
  logic [LIM_W-1:0] lim;
  logic [WIN_W-1:0] over_new;
  assign tq_mag = tq_r[TQ_W-1] ? (~{tq_r[TQ_W-1], tq_r} + 1'b1) : {1'b0, tq_r};
  always_comb begin
    case (lim_sel_r)
      2'd0:    lim = tlim_a_r;
      2'd1:    lim = tlim_b_r;
      default: lim = tlim_c_r;
    endcase
  end
  assign over_new = over_r + WIN_W'((tq_mag > {2'b00, lim}) && (over_r != '1));

  logic [SQ_W-1:0] thr;
  logic            act_plan;
  assign thr      = ds_quot[SQ_W-1:0];
  assign act_plan = (ramp_r != '0) || (coast_r != '0);

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    origin_nxt    = origin_r;
    target_nxt    = target_r;
    held_nxt      = held_r;
    dir_neg_nxt   = dir_neg_r;
    ramp_nxt      = ramp_r;
    coast_nxt     = coast_r;
    elapsed_nxt   = elapsed_r;
    win_ticks_nxt = win_ticks_r;
    over_nxt      = over_r;
    lim_sel_nxt   = lim_sel_r;
    active_nxt    = active_r;
    tripped_nxt   = tripped_r;
    dist_nxt      = dist_r;
    preg_nxt      = preg_r;
    acc_nxt       = acc_r;
    off_nxt       = off_r;
    ph_nxt        = ph_r;
    term_nxt      = term_r;
    tq_nxt        = tq_r;
    act_nxt       = act_r;
    res_nxt       = res_r;
    ds_req.start  = 1'b0;
    ds_req.op     = DS_DIV;
    ds_dividend   = '0;
    ds_divisor    = a_eff;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_START) begin
            origin_nxt    = in_data.start_pos;
            target_nxt    = in_data.end_pos;
            held_nxt      = in_data.start_pos;
            lim_sel_nxt   = in_data.joint;
            elapsed_nxt   = '0;
            win_ticks_nxt = '0;
            over_nxt      = '0;
            tripped_nxt   = 1'b0;
            active_nxt    = 1'b0;   // old move ends while the new one is planned
            dir_neg_nxt   = neg_s;
            dist_nxt      = dist_s;
            ramp_nxt      = '0;
            coast_nxt     = '0;
            st_nxt        = (dist_s == '0) ? S_PLAN_END : S_VV;
          end else if (!active_r) begin
            res_nxt = '{setpoint: held_r, moving: 1'b0, engaged: tripped_r, phase: PH_IDLE};
            st_nxt  = S_EMIT;
          end else begin
            tq_nxt   = in_data.measured_torque;
            act_nxt  = in_data.actual_pos;
            ph_nxt   = tick_ph;
            term_nxt = 1'b0;
            off_nxt  = '0;
            st_nxt   = S_MP;
          end
        end
      end
      S_VV: begin
        preg_nxt = prod;
        st_nxt   = S_THR_GO;
      end
      S_THR_GO: begin
        ds_req.start = 1'b1;
        ds_dividend  = DIV_W'(preg_r);
        st_nxt       = S_THR_W;
      end
      S_THR_W: begin
        // triangular when dist * 2^F < v^2 / a
        if (ds_done) begin
          if (thr != '0 && SQ_W'(dist_r) <= ((thr - 1'b1) >> TFB)) begin
            st_nxt = S_TRI_GO;
          end else begin
            st_nxt = S_RMP_GO;
          end
        end
      end
      S_TRI_GO: begin
        ds_req.start = 1'b1;
        ds_dividend  = {dist_r, {(3*TFB){1'b0}}};
        st_nxt       = S_TRI_W;
      end
      S_TRI_W: begin
        // root of floor(dist*2^3F / a), clipped when it needs more than 32 bits
        if (ds_done) begin
          if (ds_quot[DIV_W-1:SQ_W] != '0) begin
            ramp_nxt = RATE_MAX;
            st_nxt   = S_PLAN_END;
          end else begin
            preg_nxt = ds_quot[SQ_W-1:0];
            st_nxt   = S_SQ_GO;
          end
        end
      end
      S_SQ_GO: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_SQRT;
        ds_dividend  = DIV_W'(preg_r);
        st_nxt       = S_SQ_W;
      end
      S_SQ_W: begin
        if (ds_done) begin
          ramp_nxt = ds_quot[RATE_W-1:0];
          st_nxt   = S_PLAN_END;
        end
      end
      S_RMP_GO: begin
        ds_req.start = 1'b1;
        ds_dividend  = DIV_W'(v_eff) << TFB;
        st_nxt       = S_RMP_W;
      end
      S_RMP_W: begin
        if (ds_done) begin
          ramp_nxt = q_sat;
          st_nxt   = S_CST_GO;
        end
      end
      S_CST_GO: begin
        ds_req.start = 1'b1;
        ds_dividend  = DIV_W'(dist_r) << (2 * TFB);
        ds_divisor   = v_eff;
        st_nxt       = S_CST_W;
      end
      S_CST_W: begin
        if (ds_done) begin
          coast_nxt = (q_sat > ramp_r) ? (q_sat - ramp_r) : '0;
          st_nxt    = S_PLAN_END;
        end
      end
      S_PLAN_END: begin
        active_nxt = act_plan;
        res_nxt    = '{setpoint: origin_r, moving: act_plan, engaged: 1'b0,
                       phase: (act_plan ? PH_ACCEL : PH_IDLE)};
        st_nxt     = S_EMIT;
      end
      S_MP: begin
        preg_nxt = prod;
        st_nxt   = S_MLO;
      end
      S_MLO: begin
        acc_nxt = PROD_W'(prod);
        st_nxt  = S_MHI;
      end
      S_MHI: begin
        acc_nxt = acc_r + (PROD_W'(prod) << RATE_W);
        st_nxt  = S_ACC;
      end
      S_ACC: begin
        off_nxt = off_r + acc_sh[OFF_W-1:0];
        if (ph_r == PH_CRUISE && !term_r) begin
          term_nxt = 1'b1;
          st_nxt   = S_MP;
        end else begin
          st_nxt = S_TICK_END;
        end
      end
      S_TICK_END: begin
        held_nxt    = sp;
        elapsed_nxt = el_new;
        over_nxt    = over_new;
        res_nxt     = '{setpoint: sp, moving: 1'b1, engaged: 1'b0, phase: ph_r};
        active_nxt  = (el_new < total);
        if (win_ticks_r >= win_len_r) begin
          if (over_new > trip_cnt_r) begin
            // stall: hold the measured position and stop
            tripped_nxt = 1'b1;
            active_nxt  = 1'b0;
            held_nxt    = act_r;
            res_nxt     = '{setpoint: act_r, moving: 1'b0, engaged: 1'b1, phase: PH_IDLE};
          end else begin
            over_nxt      = '0;
            win_ticks_nxt = '0;
          end
        end else begin
          win_ticks_nxt = win_ticks_r + 1'b1;
        end
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      origin_r    <= '0;
      target_r    <= '0;
      held_r      <= '0;
      dir_neg_r   <= 1'b0;
      ramp_r      <= '0;
      coast_r     <= '0;
      elapsed_r   <= '0;
      win_ticks_r <= '0;
      over_r      <= '0;
      lim_sel_r   <= '0;
      active_r    <= 1'b0;
      tripped_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      origin_r    <= origin_nxt;
      target_r    <= target_nxt;
      held_r      <= held_nxt;
      dir_neg_r   <= dir_neg_nxt;
      ramp_r      <= ramp_nxt;
      coast_r     <= coast_nxt;
      elapsed_r   <= elapsed_nxt;
      win_ticks_r <= win_ticks_nxt;
      over_r      <= over_nxt;
      lim_sel_r   <= lim_sel_nxt;
      active_r    <= active_nxt;
      tripped_r   <= tripped_nxt;
    end
    dist_r     <= dist_nxt;
    preg_r     <= preg_nxt;
    acc_r      <= acc_nxt;
    off_r      <= off_nxt;
    ph_r       <= ph_nxt;
    term_r     <= term_nxt;
    tq_r       <= tq_nxt;
    act_r      <= act_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // register file, written only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r    <= RATE_W'(41943);
      cruise_r   <= RATE_W'(3355443);
      tlim_a_r   <= LIM_W'(200);
      tlim_b_r   <= LIM_W'(75);
      tlim_c_r   <= LIM_W'(200);
      win_len_r  <= WIN_W'(400);
      trip_cnt_r <= WIN_W'(200);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACCEL_MAG:  accel_r    <= cfg_data[RATE_W-1:0];
        CFG_CRUISE_VEL: cruise_r   <= cfg_data[RATE_W-1:0];
        CFG_TLIM_A:     tlim_a_r   <= cfg_data[LIM_W-1:0];
        CFG_TLIM_B:     tlim_b_r   <= cfg_data[LIM_W-1:0];
        CFG_TLIM_C:     tlim_c_r   <= cfg_data[LIM_W-1:0];
        CFG_WINDOW_LEN: win_len_r  <= cfg_data[WIN_W-1:0];
        CFG_TRIP_COUNT: trip_cnt_r <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = (st_r == S_IDLE);
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a trip always ends the move; a start clears the trip
  a_trip_stops: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && tripped_r))
    else $error("move active with trip latched");

  // an active move has time left
  a_time_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (elapsed_r < total))
    else $error("move active past its total time");

  // the shared unit only finishes while the sequencer waits on it
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    ds_done |-> (st_r == S_THR_W || st_r == S_TRI_W || st_r == S_SQ_W ||
                 st_r == S_RMP_W || st_r == S_CST_W))
    else $error("divider result not awaited");

  // a finished result is never overwritten while stalled
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

@@ bench/trapezoid_profile_stall_detect_tb.sv @@
`timescale 1ns / 100ps

module trapezoid_profile_stall_detect_tb;
  import tpsd_pkg::*;

  localparam logic [127:0] SAT32   = 128'hFFFF_FFFF;
  localparam logic [127:0] OFF_MAX = 128'd1 << 62;

  // Profile predictor plus the queue of setpoints it expects.
  class profile_board;
    logic [31:0] accel, cruise;
    logic [14:0] lim_a, lim_b, lim_c;
    logic [15:0] win_len, trip_thr;
    logic signed [31:0] origin, target, held;
    logic        neg, running, trip;
    logic [31:0] ramp, coast, elapsed;
    logic [15:0] win_ticks, over_cnt;
    logic [1:0]  lsel;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      accel = 32'd41943; cruise = 32'd3355443;
      lim_a = 15'd200; lim_b = 15'd75; lim_c = 15'd200;
      win_len = 16'd400; trip_thr = 16'd200;
      origin = '0; target = '0; held = '0;
      neg = 1'b0; running = 1'b0; trip = 1'b0;
      ramp = '0; coast = '0; elapsed = '0;
      win_ticks = '0; over_cnt = '0; lsel = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_ACCEL_MAG:  accel = val;
        CFG_CRUISE_VEL: cruise = val;
        CFG_TLIM_A:     lim_a = val[14:0];
        CFG_TLIM_B:     lim_b = val[14:0];
        CFG_TLIM_C:     lim_c = val[14:0];
        CFG_WINDOW_LEN: win_len = val[15:0];
        CFG_TRIP_COUNT: trip_thr = val[15:0];
        default: ;
      endcase
    endfunction

    // floor(n / d), saturated to 32 bits
    function logic [31:0] quot_sat(logic [127:0] n, logic [127:0] d);
      logic [127:0] q;
      q = n / d;
      return (q > SAT32) ? SAT32[31:0] : q[31:0];
    endfunction

    // largest t with a*t*t <= span << 3F
    function logic [31:0] ramp_root(logic [127:0] span, logic [127:0] a);
      logic [127:0] n, c;
      logic [31:0]  t;
      n = span << (3 * TFB);
      t = '0;
      for (int b = 31; b >= 0; b--) begin
        c = {96'd0, t | (32'd1 << b)};
        if (a * c * c <= n) t = c[31:0];
      end
      return t;
    endfunction

    function logic [127:0] offset(logic [127:0] a, logic [127:0] x, logic [127:0] y, int sh);
      logic [127:0] p;
      p = (a * x * y) >> sh;
      return (p > OFF_MAX) ? OFF_MAX : p;
    endfunction

    function logic [31:0] total_ticks();
      logic [127:0] t;
      t = 2 * {96'd0, ramp} + {96'd0, coast};
      return (t > SAT32) ? SAT32[31:0] : t[31:0];
    endfunction

    function void push(logic signed [31:0] sp, logic mv, logic en, logic [1:0] ph);
      out_item_t r;
      r.setpoint = sp; r.moving = mv; r.engaged = en; r.phase = ph;
      pending_q.push_back(r);
    endfunction

    function void note_item(in_item_t it);
      logic [127:0] a, v, span, thr, q, off, rem, t, r;
      logic signed [127:0] sp, lo_lim, hi_lim;
      logic signed [63:0]  diff;
      logic [31:0] tot;
      logic [1:0]  ph;
      int          mag, lim;
      a = (accel == 0) ? 128'd1 : {96'd0, accel};
      v = (cruise == 0) ? 128'd1 : {96'd0, cruise};
      if (it.func == FUNC_START) begin
        origin = it.start_pos; target = it.end_pos; held = it.start_pos;
        lsel = it.joint;
        elapsed = '0; win_ticks = '0; over_cnt = '0; trip = 1'b0;
        diff = 64'(it.end_pos) - 64'(it.start_pos);
        neg = diff < 0;
        span = neg ? {64'd0, -diff} : {64'd0, diff};
        ramp = '0; coast = '0;
        if (span != 0) begin
          thr = (v * v) / a;
          if (thr > 0 && span <= ((thr - 1) >> TFB)) begin
            // short move: triangle, no cruise
            ramp = ramp_root(span, a);
          end else begin
            ramp = quot_sat(v << TFB, a);
            q = {96'd0, quot_sat(span << (2 * TFB), v)};
            coast = (q > {96'd0, ramp}) ? q[31:0] - ramp : 32'd0;
          end
        end
        running = total_ticks() > 0;
        push(it.start_pos, running, 1'b0, running ? PH_ACCEL : PH_IDLE);
        return;
      end
      if (!running) begin
        push(held, 1'b0, trip, PH_IDLE);
        return;
      end
      tot = total_ticks();
      t = {96'd0, elapsed};
      r = {96'd0, ramp};
      if (t < r) begin
        off = offset(a, t, t, 3 * TFB + 1);
        ph = PH_ACCEL;
      end else if (t < r + {96'd0, coast}) begin
        off = offset(a, r, r, 3 * TFB + 1) + offset(a, r, t - r, 3 * TFB);
        ph = PH_CRUISE;
      end else begin
        rem = {96'd0, tot} - t;
        off = offset(a, rem, rem, 3 * TFB + 1);
        ph = PH_DECEL;
      end
      if (ph != PH_DECEL) sp = neg ? 128'(origin) - $signed(off) : 128'(origin) + $signed(off);
      else                sp = neg ? 128'(target) + $signed(off) : 128'(target) - $signed(off);
      hi_lim = 128'sd2147483647;
      lo_lim = -128'sd2147483648;
      if (sp > hi_lim) sp = hi_lim;
      if (sp < lo_lim) sp = lo_lim;
      held = sp[31:0];
      elapsed = (elapsed > 32'hFFFF_FFFF - 32'h1_0000) ? 32'hFFFF_FFFF : elapsed + 32'h1_0000;
      mag = int'(it.measured_torque);
      if (mag < 0) mag = -mag;
      lim = (lsel == 2'd0) ? int'(lim_a) : (lsel == 2'd1) ? int'(lim_b) : int'(lim_c);
      if (mag > lim && over_cnt != 16'hFFFF) over_cnt++;
      if (win_ticks >= win_len) begin
        if (over_cnt > trip_thr) begin
          trip = 1'b1; running = 1'b0; held = it.actual_pos;
          push(it.actual_pos, 1'b0, 1'b1, PH_IDLE);
          return;
        end
        over_cnt = '0; win_ticks = '0;
      end else begin
        win_ticks++;
      end
      if (elapsed >= tot) running = 1'b0;
      push(sp[31:0], 1'b1, 1'b0, ph);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: setpoint %0d", got.setpoint);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.setpoint !== exp_r.setpoint) begin
        $error("setpoint: expected %0d, actual %0d", exp_r.setpoint, got.setpoint);
        errors++;
      end
      if (got.moving !== exp_r.moving) begin
        $error("moving: expected %0d, actual %0d", exp_r.moving, got.moving);
        errors++;
      end
      if (got.engaged !== exp_r.engaged) begin
        $error("engaged: expected %0d, actual %0d", exp_r.engaged, got.engaged);
        errors++;
      end
      if (got.phase !== exp_r.phase) begin
        $error("phase: expected %0d, actual %0d", exp_r.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  profile_board sb;
  bit           quiet;      // final stretch: no idling on either side
  int           hold_req;   // long receiver hold-off request, in cycles

  trapezoid_profile_stall_detect dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #50ms;
    $display("trapezoid_profile_stall_detect_tb: FAIL");
    $finish;
  end

  // Result side: check every accepted item, stall in random bursts,
  // and honor a long hold-off when the driver asks for one.
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(5) == 0) begin
        burst = $urandom_range(15, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item; valid stays high into the next item unless a gap follows.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  task automatic send_start(logic [1:0] jnt, logic [31:0] p0, logic [31:0] p1);
    in_item_t it;
    it.func = FUNC_START;
    it.joint = jnt;
    it.start_pos = p0;
    it.end_pos = p1;
    it.measured_torque = 16'($urandom);
    it.actual_pos = $urandom;
    send_item(it);
  endtask

  task automatic send_tick(logic [15:0] tq, logic [31:0] act);
    in_item_t it;
    it.func = FUNC_TICK;
    it.joint = 2'($urandom);
    it.start_pos = $urandom;
    it.end_pos = $urandom;
    it.measured_torque = tq;
    it.actual_pos = act;
    send_item(it);
  endtask

  // Wait for the block to drain, then write a register.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);   // settle margin; the block idles once its last result is out
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_profile(logic [31:0] acc, logic [31:0] vel, logic [15:0] wl,
                             logic [15:0] tc, logic [14:0] la, logic [14:0] lb,
                             logic [14:0] lc);
    write_reg(CFG_ACCEL_MAG, acc);
    write_reg(CFG_CRUISE_VEL, vel);
    write_reg(CFG_WINDOW_LEN, {16'd0, wl});
    write_reg(CFG_TRIP_COUNT, {16'd0, tc});
    write_reg(CFG_TLIM_A, {17'd0, la});
    write_reg(CFG_TLIM_B, {17'd0, lb});
    write_reg(CFG_TLIM_C, {17'd0, lc});
  endtask

  function automatic logic [15:0] pick_torque();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom);
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  // Mostly well-formed moves: a start followed by a run of ticks, with
  // stray ticks mixed in. Distances are mostly short so moves finish.
  task automatic random_moves(int n_items);
    int          sent;
    int          run;
    logic [31:0] p0;
    logic [31:0] p1;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_tick(pick_torque(), $urandom);
        sent++;
      end else begin
        p0 = ($urandom_range(7) == 0) ? $urandom : 32'($signed($urandom_range(20000)) - 10000);
        case ($urandom_range(9))
          0:       p1 = p0;
          1:       p1 = $urandom;
          default: p1 = p0 + 32'($signed($urandom_range(4000)) - 2000);
        endcase
        send_start(2'($urandom), p0, p1);
        run = $urandom_range(40, 1);
        for (int k = 0; k < run; k++) send_tick(pick_torque(), $urandom);
        sent += run + 1;
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ACCEL_MAG;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick straight out of reset, extreme fields.
    send_tick(16'h8000, 32'h8000_0000);
    send_start(2'd0, 32'h8000_0000, 32'h7FFF_FFFF);   // longest move up
    send_tick(16'h7FFF, 32'h7FFF_FFFF);
    send_tick(16'h0000, 32'h0000_0000);
    send_start(2'd3, 32'h7FFF_FFFF, 32'h8000_0000);   // longest move down, joint three
    send_tick(16'hFFFF, 32'hFFFF_FFFF);
    send_start(2'd1, 32'd5, 32'd5);                   // zero distance: no move
    send_tick(16'd100, 32'd1);
    send_start(2'd2, 32'd0, 32'd1);                   // one count
    send_tick(16'd0, 32'd0);
    send_start(2'd0, -32'sd100, 32'd100);             // start during a move
    send_tick(16'd0, 32'd0);

    // Fast profile, window closing every tick and tripping on one sample.
    set_profile(32'h0010_0000, 32'h0040_0000, 16'd0, 16'd0, 15'd0, 15'd0, 15'd0);
    send_start(2'd1, 32'd0, 32'd500);
    send_tick(16'd0, 32'd0);                          // no over-limit: window clears
    send_tick(16'd1, 32'd1234);                       // trip, setpoint from actual
    send_tick(16'd1, 32'd0);                          // idle, engaged held
    send_start(2'd2, 32'd500, 32'd0);                 // start clears the trip
    send_tick(16'd0, 32'd0);

    // Steepest accel with slowest cruise, then the reverse and zero rates.
    set_profile(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    random_moves(60);
    set_profile(32'd1, 32'hFFFF_FFFF, 16'd3, 16'd1, 15'd50, 15'd10, 15'd150);
    random_moves(40);
    set_profile(32'd0, 32'd0, 16'd2, 16'd0, 15'd100, 15'd100, 15'd100);
    random_moves(40);

    // Mid-range, trips common; a long receiver hold-off fills the block.
    set_profile(32'h0008_0000, 32'h0020_0000, 16'd4, 16'd2, 15'd150, 15'd60, 15'd180);
    hold_req = 400;
    random_moves(200);

    // Back near the reset rates with a short window.
    set_profile(32'd41943, 32'd3355443, 16'd20, 16'd10, 15'd200, 15'd75, 15'd200);
    random_moves(200);

    // Final stretch with no idling at all.
    set_profile(32'h0020_0000, 32'h0080_0000, 16'd6, 16'd3, 15'd120, 15'd80, 15'd160);
    quiet = 1'b1;
    random_moves(200);
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("trapezoid_profile_stall_detect_tb: PASS");
    end else begin
      $display("trapezoid_profile_stall_detect_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tpsd_pkg.sv
design/tpsd_divsqrt.sv
design/trapezoid_profile_stall_detect.sv
bench/trapezoid_profile_stall_detect_tb.sv
